[design/rgb_pulse_color_classifier_core_macros.svh]
// assertion macros for the rgb pulse color classifier core
// used by the top level only; expects clk and arst_n in scope
`ifndef RGB_PULSE_COLOR_CLASSIFIER_CORE_MACROS_SVH
`define RGB_PULSE_COLOR_CLASSIFIER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define RPCC_ASSERT_IMPL(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rpcc assertion failed");
// next-cycle implication
`define RPCC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rpcc assertion failed");
`else
`define RPCC_ASSERT_IMPL(label, ante, cons)
`define RPCC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

[design/rpcc_pkg.sv]
// shared types, constants and the width-to-level function of the color classifier
// no dependencies
package rpcc_pkg;

	localparam int unsigned WIDTH_W = 12;
	localparam int unsigned LEVEL_W = 16;
	localparam int unsigned LIMIT_W = 10;
	localparam int unsigned CFG_INDEX_W = 2;

	// pulse width offsets of the linear map
	localparam logic [5:0] OFFSET_RG = 6'd50;
	localparam logic [5:0] OFFSET_B = 6'd45;
	// floor(m / 10) as (m * RECIP_10) >> 16, exact for m below 4096
	localparam logic [12:0] RECIP_10 = 13'd6554;

	// register reset values
	localparam logic [LIMIT_W-1:0] DELTA_LIMIT_RST = 10'd30;
	localparam logic [LIMIT_W-1:0] DARK_LIMIT_RST = 10'd80;
	localparam logic [LIMIT_W-1:0] BRIGHT_LIMIT_RST = 10'd380;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DELTA_LIMIT = 2'd0,
		REG_DARK_LIMIT = 2'd1,
		REG_BRIGHT_LIMIT = 2'd2
	} cfg_reg_t;

	typedef enum logic [3:0] {
		CLS_BLACK = 4'd0,
		CLS_WHITE = 4'd1,
		CLS_GREY = 4'd2,
		CLS_YELLOW = 4'd3,
		CLS_ORANGE = 4'd4,
		CLS_PINK = 4'd5,
		CLS_RED = 4'd6,
		CLS_CYAN = 4'd7,
		CLS_PURPLE = 4'd8,
		CLS_BLUE = 4'd9,
		CLS_GREEN = 4'd10,
		CLS_INVALID = 4'd11
	} color_class_t;

	typedef struct packed {
		logic [LIMIT_W-1:0] delta_limit;
		logic [LIMIT_W-1:0] dark_limit;
		logic [LIMIT_W-1:0] bright_limit;
	} cfg_t;

	typedef struct packed {
		logic [WIDTH_W-1:0] red_width;
		logic [WIDTH_W-1:0] green_width;
		logic [WIDTH_W-1:0] blue_width;
	} widths_t;

	typedef struct packed {
		logic signed [LEVEL_W-1:0] red_level;
		logic signed [LEVEL_W-1:0] green_level;
		logic signed [LEVEL_W-1:0] blue_level;
	} levels_t;

	typedef struct packed {
		color_class_t color_class;
		logic signed [LEVEL_W-1:0] red_level;
		logic signed [LEVEL_W-1:0] green_level;
		logic signed [LEVEL_W-1:0] blue_level;
	} result_t;

	// level = 255 - trunc(51 * (w - ofs) / 10), unclamped
	function automatic logic signed [LEVEL_W-1:0] map_level(
		input logic [WIDTH_W-1:0] w,
		input logic [5:0] ofs
	);
		logic signed [12:0] x;
		logic [11:0] m;
		logic [24:0] prod;
		logic [14:0] mag;
		x = $signed({1'b0, w}) - $signed({7'b0, ofs});
		m = x[12] ? 12'(-x) : x[11:0];
		prod = 25'(m) * 25'(RECIP_10);
		mag = 15'(m) * 15'd5 + 15'(prod[24:16]);
		if (x[12]) begin
			map_level = 16'sd255 + $signed({1'b0, mag});
		end else begin
			map_level = 16'sd255 - $signed({1'b0, mag});
		end
	endfunction

endpackage

[design/rpcc_level_map.sv]
// maps the three pulse widths to signed color levels
// depends on rpcc_pkg
module rpcc_level_map (
	input  rpcc_pkg::widths_t widths,
	output rpcc_pkg::levels_t levels
);
	import rpcc_pkg::*;

	// red and green share an offset, blue has its own
	assign levels.red_level = map_level(widths.red_width, OFFSET_RG);
	assign levels.green_level = map_level(widths.green_width, OFFSET_RG);
	assign levels.blue_level = map_level(widths.blue_width, OFFSET_B);

endmodule

[design/rpcc_classify.sv]
// decision tree from three color levels to one of twelve classes
// depends on rpcc_pkg
module rpcc_classify (
	input  rpcc_pkg::levels_t levels,
	input  rpcc_pkg::cfg_t cfg,
	output rpcc_pkg::color_class_t color_class
);
	import rpcc_pkg::*;

	logic signed [16:0] r, g, b;
	logic signed [16:0] dark, bright;
	logic signed [16:0] diff_rg, diff_rb, diff_gb;
	logic [15:0] ad_rg, ad_rb, ad_gb;
	logic [18:0] d1, d2, d3, d5;
	logic [18:0] ad_rg_x, ad_rb_x2, ad_gb_x, ad_gb_x5;
	logic is_black, is_white, is_grey;
	logic r_dom, g_dom, b_dom;

	// sign extend levels, zero extend limits
	assign r = 17'(levels.red_level);
	assign g = 17'(levels.green_level);
	assign b = 17'(levels.blue_level);
	assign dark = $signed({7'b0, cfg.dark_limit});
	assign bright = $signed({7'b0, cfg.bright_limit});

	// pairwise absolute differences
	assign diff_rg = r - g;
	assign diff_rb = r - b;
	assign diff_gb = g - b;
	assign ad_rg = diff_rg[16] ? 16'(-diff_rg) : diff_rg[15:0];
	assign ad_rb = diff_rb[16] ? 16'(-diff_rb) : diff_rb[15:0];
	assign ad_gb = diff_gb[16] ? 16'(-diff_gb) : diff_gb[15:0];

	// scaled thresholds and differences for the 2.5 and 0.6 factors
	assign d1 = 19'(cfg.delta_limit);
	assign d2 = 19'(cfg.delta_limit) * 19'd2;
	assign d3 = 19'(cfg.delta_limit) * 19'd3;
	assign d5 = 19'(cfg.delta_limit) * 19'd5;
	assign ad_rg_x = 19'(ad_rg);
	assign ad_rb_x2 = 19'(ad_rb) * 19'd2;
	assign ad_gb_x = 19'(ad_gb);
	assign ad_gb_x5 = 19'(ad_gb) * 19'd5;

	// top-level decisions
	assign is_black = (r < dark) && (g < dark) && (b < dark);
	assign is_white = (r > bright) && (g > bright) && (b > bright);
	assign is_grey = (ad_rg_x < d1) && (19'(ad_rb) < d1) && (ad_gb_x < d1);
	assign r_dom = (r > g) && (r > b);
	assign b_dom = (b > r) && (b > g);
	assign g_dom = (g > r) && (g > b);

	// priority tree
	always_comb begin
		if (is_black) begin
			color_class = CLS_BLACK;
		end else if (is_white) begin
			color_class = CLS_WHITE;
		end else if (is_grey) begin
			color_class = CLS_GREY;
		end else if (r_dom) begin
			if (ad_rg_x < d1) begin
				color_class = CLS_YELLOW;
			end else if (ad_rg_x < d2) begin
				color_class = CLS_ORANGE;
			end else if (19'(ad_rb) < d2) begin
				color_class = CLS_PINK;
			end else begin
				color_class = CLS_RED;
			end
		end else if (b_dom) begin
			if (ad_gb_x < d1) begin
				color_class = CLS_CYAN;
			end else if (ad_rb_x2 < d5) begin
				color_class = CLS_PURPLE;
			end else begin
				color_class = CLS_BLUE;
			end
		end else if (g_dom) begin
			if (ad_rg_x < d1) begin
				color_class = CLS_YELLOW;
			end else if (ad_gb_x5 < d3) begin
				color_class = CLS_CYAN;
			end else begin
				color_class = CLS_GREEN;
			end
		end else begin
			color_class = CLS_INVALID;
		end
	end

endmodule

[design/rgb_pulse_color_classifier_core.sv]
// top level of the rgb pulse color classifier: input register, level map,
// classifier and result register; depends on rpcc_pkg, rpcc_level_map,
// rpcc_classify and rgb_pulse_color_classifier_core_macros.svh
//
// channel   signals                        beat taken when
// -------   ----------------------------   -------------------------------
// input     start, busy, widths            start high and busy low
// result    done, result                   every cycle done is high
// config    cfg_valid, cfg_ready,          cfg_valid and cfg_ready high
//           cfg_index, cfg_data
//
// one beat per cycle in, one result per beat out; each beat passes the input
// register and then the result register
// busy and cfg_ready are always low and high; the map and the tree fit in
// the single stage between the two registers
// reset clears the valid flags and loads the register defaults
// results are shown for one cycle only; the receiver has no stall
module rgb_pulse_color_classifier_core (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  rpcc_pkg::widths_t widths,
	output logic done,
	output rpcc_pkg::result_t result,
	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic [rpcc_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [rpcc_pkg::LIMIT_W-1:0] cfg_data
);
	import rpcc_pkg::*;

	`include "rgb_pulse_color_classifier_core_macros.svh"

	cfg_t cfg_q;
	widths_t widths_s1;
	logic valid_s1;
	levels_t levels;
	color_class_t color_class;
	result_t result_s2;
	logic valid_s2;
	logic accept;

	assign busy = 1'b0;
	assign cfg_ready = 1'b1;
	assign accept = start && !busy;

	// configuration registers, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.delta_limit <= DELTA_LIMIT_RST;
			cfg_q.dark_limit <= DARK_LIMIT_RST;
			cfg_q.bright_limit <= BRIGHT_LIMIT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_DELTA_LIMIT: cfg_q.delta_limit <= cfg_data;
				REG_DARK_LIMIT: cfg_q.dark_limit <= cfg_data;
				REG_BRIGHT_LIMIT: cfg_q.bright_limit <= cfg_data;
				default: ;
			endcase
		end
	end

	// input stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	// input stage payload
	always_ff @(posedge clk) begin
		if (accept) begin
			widths_s1 <= widths;
		end
	end

	rpcc_level_map u_level_map (
		.widths(widths_s1),
		.levels(levels)
	);

	rpcc_classify u_classify (
		.levels(levels),
		.cfg(cfg_q),
		.color_class(color_class)
	);

	// result stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	// result stage payload
	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2.color_class <= color_class;
			result_s2.red_level <= levels.red_level;
			result_s2.green_level <= levels.green_level;
			result_s2.blue_level <= levels.blue_level;
		end
	end

	assign done = valid_s2;
	assign result = result_s2;

	// checks
	`RPCC_ASSERT_NEXT(a_s1_follows_accept, accept, valid_s1)
	`RPCC_ASSERT_IMPL(a_done_two_after_accept, accept, ##2 done)
	`RPCC_ASSERT_IMPL(a_done_has_source, done, $past(accept, 2))
	`RPCC_ASSERT_IMPL(a_class_in_range, done, result.color_class <= CLS_INVALID)

endmodule

[bench/rgb_pulse_color_classifier_core_test.sv]
// self-checking testbench for rgb_pulse_color_classifier_core: directed and random
// width triples under several register settings, checked against an inline predictor
// depends on rpcc_pkg and the design sources
module rgb_pulse_color_classifier_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import rpcc_pkg::*;

	// no register behind this index, writes to it must be dropped
	localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_UNUSED = 2'd3;
	localparam int unsigned MAX_PRINTED = 100;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	widths_t widths;
	logic done;
	result_t result;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [LIMIT_W-1:0] cfg_data;

	// predictor copy of the registers and results still owed by the block
	cfg_t model_cfg;
	result_t expected_colors[$];
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	int unsigned mismatches = 0;
	int unsigned burst_left = 0;

	rgb_pulse_color_classifier_core dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.widths(widths),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// run limit
	initial begin
		#400000;
		$display("[rgb_pulse_color_classifier_core] ERROR");
		$finish;
	end

	// inverse linear map, division truncates toward zero, no clamp
	function automatic int map_width(input logic [WIDTH_W-1:0] w, input int ofs);
		return ((int'(w) - ofs) * -255) / 50 + 255;
	endfunction

	function automatic int abs_gap(input int a, input int b);
		return (a > b) ? a - b : b - a;
	endfunction

	// decision tree; the 2.5 and 0.6 factors are scaled to integer compares
	function automatic color_class_t classify_levels(input int r, input int g, input int b,
			input cfg_t c);
		int d;
		int dark;
		int bright;
		d = int'(c.delta_limit);
		dark = int'(c.dark_limit);
		bright = int'(c.bright_limit);
		if (r < dark && g < dark && b < dark) return CLS_BLACK;
		if (r > bright && g > bright && b > bright) return CLS_WHITE;
		if (abs_gap(r, g) < d && abs_gap(r, b) < d && abs_gap(g, b) < d) return CLS_GREY;
		if (r > g && r > b) begin
			if (abs_gap(g, r) < d) return CLS_YELLOW;
			if (abs_gap(g, r) < 2 * d) return CLS_ORANGE;
			if (abs_gap(b, r) < 2 * d) return CLS_PINK;
			return CLS_RED;
		end
		if (b > r && b > g) begin
			if (abs_gap(b, g) < d) return CLS_CYAN;
			if (2 * abs_gap(b, r) < 5 * d) return CLS_PURPLE;
			return CLS_BLUE;
		end
		if (g > r && g > b) begin
			if (abs_gap(r, g) < d) return CLS_YELLOW;
			if (5 * abs_gap(b, g) < 3 * d) return CLS_CYAN;
			return CLS_GREEN;
		end
		return CLS_INVALID;
	endfunction

	function automatic result_t predict_color(input widths_t w, input cfg_t c);
		result_t p;
		int r;
		int g;
		int b;
		r = map_width(w.red_width, 50);
		g = map_width(w.green_width, 50);
		b = map_width(w.blue_width, 45);
		p.color_class = classify_levels(r, g, b, c);
		p.red_level = 16'(r);
		p.green_level = 16'(g);
		p.blue_level = 16'(b);
		return p;
	endfunction

	task automatic note_mismatch(input string msg);
		mismatches++;
		if (mismatches <= MAX_PRINTED) $display("mismatch: %s", msg);
	endtask

	// result checker, one beat per done cycle
	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (expected_colors.size() == 0) begin
				note_mismatch($sformatf("result %0d with nothing outstanding", results_seen));
			end else begin
				want = expected_colors.pop_front();
				if (result.color_class !== want.color_class)
					note_mismatch($sformatf("result %0d color_class %0d, expected %0d",
						results_seen, result.color_class, want.color_class));
				if (result.red_level !== want.red_level)
					note_mismatch($sformatf("result %0d red_level %0d, expected %0d",
						results_seen, result.red_level, want.red_level));
				if (result.green_level !== want.green_level)
					note_mismatch($sformatf("result %0d green_level %0d, expected %0d",
						results_seen, result.green_level, want.green_level));
				if (result.blue_level !== want.blue_level)
					note_mismatch($sformatf("result %0d blue_level %0d, expected %0d",
						results_seen, result.blue_level, want.blue_level));
			end
			results_seen++;
		end
	end

	// idle gap before a beat, with occasional back-to-back stretches
	function automatic int unsigned draw_gap();
		if (burst_left != 0) begin
			burst_left--;
			return 0;
		end
		if ($urandom_range(0, 29) == 0) burst_left = $urandom_range(20, 60);
		return $urandom_range(0, 10);
	endfunction

	// one input beat; start stays high across back-to-back beats
	task automatic send_widths(input widths_t w, input int unsigned gap);
		if (gap != 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		widths <= w;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_colors.push_back(predict_color(w, model_cfg));
		items_sent++;
	endtask

	task automatic wait_for_results();
		start <= 1'b0;
		@(posedge clk);
		while (results_seen != items_sent) @(posedge clk);
	endtask

	task automatic write_register(input logic [CFG_INDEX_W-1:0] idx,
			input logic [LIMIT_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			REG_DELTA_LIMIT: model_cfg.delta_limit = data;
			REG_DARK_LIMIT: model_cfg.dark_limit = data;
			REG_BRIGHT_LIMIT: model_cfg.bright_limit = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// registers are only touched with nothing in flight
	task automatic load_config(input cfg_t c);
		wait_for_results();
		write_register(REG_DELTA_LIMIT, c.delta_limit);
		write_register(REG_DARK_LIMIT, c.dark_limit);
		write_register(REG_BRIGHT_LIMIT, c.bright_limit);
	endtask

	function automatic logic [WIDTH_W-1:0] clip_width(input int v);
		if (v < 0) return '0;
		if (v > 4095) return 12'hFFF;
		return v[WIDTH_W-1:0];
	endfunction

	// mostly widths in the range where levels land near -180..510, plus ties and full range
	function automatic widths_t random_widths();
		widths_t w;
		int base;
		int unsigned mode;
		mode = $urandom_range(0, 9);
		case (mode)
			0, 1, 2: begin
				w.red_width = WIDTH_W'($urandom_range(0, 130));
				w.green_width = WIDTH_W'($urandom_range(0, 130));
				w.blue_width = WIDTH_W'($urandom_range(0, 130));
			end
			3, 4, 5: begin
				base = int'($urandom_range(0, 120));
				w.red_width = clip_width(base + int'($urandom_range(0, 30)) - 15);
				w.green_width = clip_width(base + int'($urandom_range(0, 30)) - 15);
				w.blue_width = clip_width(base + int'($urandom_range(0, 30)) - 20);
			end
			6: begin
				// two channels at the same level; blue matches at five less
				base = int'($urandom_range(5, 130));
				w.red_width = WIDTH_W'($urandom_range(0, 130));
				w.green_width = WIDTH_W'($urandom_range(0, 130));
				w.blue_width = WIDTH_W'($urandom_range(0, 130));
				case ($urandom_range(0, 2))
					0: begin
						w.red_width = WIDTH_W'(base);
						w.green_width = WIDTH_W'(base);
					end
					1: begin
						w.red_width = WIDTH_W'(base);
						w.blue_width = WIDTH_W'(base - 5);
					end
					default: begin
						w.green_width = WIDTH_W'(base);
						w.blue_width = WIDTH_W'(base - 5);
					end
				endcase
			end
			7, 8: begin
				w.red_width = WIDTH_W'($urandom);
				w.green_width = WIDTH_W'($urandom);
				w.blue_width = WIDTH_W'($urandom);
			end
			default: begin
				w.red_width = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
				w.green_width = $urandom_range(0, 1) ? 12'hFFF : WIDTH_W'($urandom);
				w.blue_width = $urandom_range(0, 1) ? 12'h000 : WIDTH_W'($urandom);
			end
		endcase
		return w;
	endfunction

	function automatic cfg_t random_config();
		cfg_t c;
		if ($urandom_range(0, 2) == 0) begin
			c.delta_limit = LIMIT_W'($urandom);
			c.dark_limit = LIMIT_W'($urandom);
			c.bright_limit = LIMIT_W'($urandom);
		end else begin
			c.delta_limit = LIMIT_W'($urandom_range(0, 90));
			c.dark_limit = LIMIT_W'($urandom_range(0, 200));
			c.bright_limit = LIMIT_W'($urandom_range(150, 520));
		end
		return c;
	endfunction

	// extremes of the width fields and alternating bit patterns
	task automatic test_width_extremes();
		send_widths('{red_width: 12'h000, green_width: 12'h000, blue_width: 12'h000}, 0);
		send_widths('{red_width: 12'hFFF, green_width: 12'hFFF, blue_width: 12'hFFF}, 0);
		send_widths('{red_width: 12'hFFF, green_width: 12'h000, blue_width: 12'h000}, 1);
		send_widths('{red_width: 12'h000, green_width: 12'hFFF, blue_width: 12'h000}, 0);
		send_widths('{red_width: 12'h000, green_width: 12'h000, blue_width: 12'hFFF}, 2);
		send_widths('{red_width: 12'hAAA, green_width: 12'h555, blue_width: 12'hAAA}, 0);
		send_widths('{red_width: 12'h555, green_width: 12'hAAA, blue_width: 12'h555}, 0);
	endtask

	// one triple per branch of the tree at the reset settings
	task automatic test_every_class();
		send_widths('{red_width: 12'd1000, green_width: 12'd1000, blue_width: 12'd1000}, 0);
		send_widths('{red_width: 12'd0, green_width: 12'd0, blue_width: 12'd0}, 0);
		send_widths('{red_width: 12'd50, green_width: 12'd50, blue_width: 12'd45}, 3);
		send_widths('{red_width: 12'd50, green_width: 12'd54, blue_width: 12'd100}, 0);
		send_widths('{red_width: 12'd50, green_width: 12'd60, blue_width: 12'd100}, 0);
		send_widths('{red_width: 12'd50, green_width: 12'd100, blue_width: 12'd50}, 1);
		send_widths('{red_width: 12'd50, green_width: 12'd100, blue_width: 12'd100}, 0);
		send_widths('{red_width: 12'd100, green_width: 12'd54, blue_width: 12'd45}, 0);
		send_widths('{red_width: 12'd60, green_width: 12'd100, blue_width: 12'd45}, 0);
		send_widths('{red_width: 12'd100, green_width: 12'd100, blue_width: 12'd45}, 2);
		send_widths('{red_width: 12'd54, green_width: 12'd50, blue_width: 12'd100}, 0);
		send_widths('{red_width: 12'd100, green_width: 12'd50, blue_width: 12'd48}, 0);
		send_widths('{red_width: 12'd100, green_width: 12'd50, blue_width: 12'd100}, 0);
		// tie for the maximum
		send_widths('{red_width: 12'd50, green_width: 12'd50, blue_width: 12'd100}, 0);
	endtask

	// register extremes, limits out of order, and a write to the unused index
	task automatic test_register_extremes();
		cfg_t settings[6];
		settings[0] = '{delta_limit: 10'd0, dark_limit: 10'd0, bright_limit: 10'd0};
		settings[1] = '{delta_limit: 10'd1023, dark_limit: 10'd1023,
			bright_limit: 10'd1023};
		settings[2] = '{delta_limit: 10'd0, dark_limit: 10'd1023, bright_limit: 10'd0};
		settings[3] = '{delta_limit: 10'd1023, dark_limit: 10'd0, bright_limit: 10'd1023};
		settings[4] = '{delta_limit: 10'd1, dark_limit: 10'd500, bright_limit: 10'd100};
		settings[5] = '{delta_limit: 10'd30, dark_limit: 10'd80, bright_limit: 10'd380};
		foreach (settings[i]) begin
			load_config(settings[i]);
			if (i == 5) write_register(CFG_INDEX_UNUSED, LIMIT_W'($urandom));
			send_widths('{red_width: 12'h000, green_width: 12'h000, blue_width: 12'h000}, 0);
			send_widths('{red_width: 12'hFFF, green_width: 12'hFFF, blue_width: 12'hFFF}, 0);
			repeat (8) send_widths(random_widths(), draw_gap());
		end
	endtask

	// random triples over several random settings
	task automatic test_random_widths();
		for (int phase = 0; phase < 8; phase++) begin
			load_config(random_config());
			for (int n = 0; n < 170; n++) begin
				// hold off until the block has drained
				if ($urandom_range(0, 99) == 0) wait_for_results();
				send_widths(random_widths(), draw_gap());
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		widths <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		model_cfg = '{delta_limit: DELTA_LIMIT_RST, dark_limit: DARK_LIMIT_RST,
			bright_limit: BRIGHT_LIMIT_RST};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_every_class();
		test_width_extremes();
		test_register_extremes();
		test_random_widths();

		// drain and let the pipeline settle
		wait_for_results();
		repeat (8) @(posedge clk);
		if (expected_colors.size() != 0)
			note_mismatch($sformatf("%0d results never arrived", expected_colors.size()));
		if (mismatches == 0) begin
			$display("[rgb_pulse_color_classifier_core] OK");
		end else begin
			$display("[rgb_pulse_color_classifier_core] ERROR");
		end
		$finish;
	end

endmodule

[filelist.f]
+incdir+design
design/rpcc_pkg.sv
design/rpcc_level_map.sv
design/rpcc_classify.sv
design/rgb_pulse_color_classifier_core.sv
bench/rgb_pulse_color_classifier_core_test.sv
